@@ hdl/u16dw_pkg.sv @@
// Shared constants and the column width table for the UTF-16 display width unit.
package u16dw_pkg;

  // Longest string the sum is sized for, and the saturation point derived from it
  localparam int unsigned MaxUnits   = 65535;
  localparam int unsigned WidthLimit = 131070;
  localparam int unsigned WidthCapInt =
      (2 * MaxUnits < WidthLimit) ? (2 * MaxUnits) : WidthLimit;

  localparam int unsigned SumW = 17;
  localparam logic [SumW-1:0] WidthCap = SumW'(WidthCapInt);

  localparam int unsigned UnitW = 16;
  localparam int unsigned CpW   = 21;

  // Surrogate ranges and the supplementary plane offset
  localparam logic [UnitW-1:0] HighFirst = 16'hD800;
  localparam logic [UnitW-1:0] HighLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LowFirst  = 16'hDC00;
  localparam logic [UnitW-1:0] LowLast   = 16'hDFFF;
  localparam logic [CpW-1:0]   SuppBase  = 21'h10000;

  // Check one code point against a closed range
  function automatic logic in_range(input logic [CpW-1:0] cp,
                                    input logic [CpW-1:0] lo,
                                    input logic [CpW-1:0] hi);
    in_range = (cp >= lo) && (cp <= hi);
  endfunction

  // Console columns of one code point: 0, 1 or 2
  function automatic logic [1:0] cp_columns(input logic [CpW-1:0] cp);
    logic zero_w;
    logic wide_w;
    zero_w = (cp < 21'h20) || in_range(cp, 21'h7F, 21'h9F) ||
             in_range(cp, 21'h0300, 21'h036F) || in_range(cp, 21'h1AB0, 21'h1AFF) ||
             in_range(cp, 21'h1DC0, 21'h1DFF) || in_range(cp, 21'h20D0, 21'h20FF) ||
             in_range(cp, 21'hFE00, 21'hFE0F) || in_range(cp, 21'hFE20, 21'hFE2F) ||
             (cp == 21'h200D);
    wide_w = in_range(cp, 21'h1100, 21'h115F) || (cp == 21'h2329) || (cp == 21'h232A) ||
             in_range(cp, 21'h2E80, 21'hA4CF) || in_range(cp, 21'hAC00, 21'hD7A3) ||
             in_range(cp, 21'hF900, 21'hFAFF) || in_range(cp, 21'hFE10, 21'hFE19) ||
             in_range(cp, 21'hFE30, 21'hFE6F) || in_range(cp, 21'hFF00, 21'hFF60) ||
             in_range(cp, 21'hFFE0, 21'hFFE6) || in_range(cp, 21'h1F300, 21'h1FAFF) ||
             in_range(cp, 21'h20000, 21'h3FFFD);
    if (zero_w) begin
      cp_columns = 2'd0;
    end else if (wide_w) begin
      cp_columns = 2'd2;
    end else begin
      cp_columns = 2'd1;
    end
  endfunction

endpackage

@@ hdl/utf16_display_width_unit.sv @@
// Top level of the UTF-16 display width unit: input register, width logic, result register.
//
// Usage: send a string as UTF-16 code units on the input channel, one unit
// per transaction, with last_unit_i high on the final unit (a string holds at
// least one unit). Surrogate pairs are joined; lone surrogates count as one
// column. One transaction leaves on the output channel per string, carrying
// the total column count, saturating at the package cap.
// Throughput: one code unit per cycle while no final unit is held by a waiting
// result, set by the loop through the width table, one adder and the saturation
// compare into the running sum. Output path: the final unit goes from the input
// register to the result register, where a waiting result can hold it back.
// Stall: while a result waits, units that are not last still pass through and
// update the sum; a further last unit waits in the input register, and
// in_ready_o falls only once that register is blocked.
// Reset: asynchronous, active low; clears the pending surrogate, the sum and
// both valid flags, so no transaction is in flight afterwards.
module utf16_display_width_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] total_width_o
);

  // Input register
  logic                         s1_valid_q, s1_valid_d;
  logic [u16dw_pkg::UnitW-1:0]  s1_code_q;
  logic                         s1_last_q;

  // String state
  logic                         high_pending_q, high_pending_d;
  logic [9:0]                   held_high_q, held_high_d;
  logic [u16dw_pkg::SumW-1:0]   width_sum_q, width_sum_d;

  // Result register
  logic                         out_valid_q, out_valid_d;
  logic [u16dw_pkg::SumW-1:0]   out_width_q;

  logic                         out_free;
  logic                         s1_fire;
  logic                         is_high, is_low;
  logic [u16dw_pkg::CpW-1:0]    pair_cp;
  logic [1:0]                   cur_cols;
  logic [1:0]                   add_cols;
  logic [u16dw_pkg::SumW:0]     sum_ext;
  logic [u16dw_pkg::SumW-1:0]   sum_sat;

  // Advance the input register when its unit yields no result or the result slot frees
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign s1_valid_d = (in_valid_i && in_ready_o) || (s1_valid_q && !s1_fire);

  // Classify the unit and pick the columns it adds
  assign is_high = (s1_code_q >= u16dw_pkg::HighFirst) && (s1_code_q <= u16dw_pkg::HighLast);
  assign is_low  = (s1_code_q >= u16dw_pkg::LowFirst) && (s1_code_q <= u16dw_pkg::LowLast);
  assign pair_cp = u16dw_pkg::SuppBase + {1'b0, held_high_q, s1_code_q[9:0]};

  always_comb begin
    high_pending_d = high_pending_q;
    held_high_d    = held_high_q;
    cur_cols       = 2'd0;
    add_cols       = 2'd0;
    if (high_pending_q && is_low) begin
      // Join the pair into one supplementary code point
      add_cols       = u16dw_pkg::cp_columns(pair_cp);
      high_pending_d = 1'b0;
      held_high_d    = '0;
    end else begin
      // A held high without its low counts as one column on its own
      if (is_high && !s1_last_q) begin
        high_pending_d = 1'b1;
        held_high_d    = s1_code_q[9:0];
      end else begin
        cur_cols       = u16dw_pkg::cp_columns({5'd0, s1_code_q});
        high_pending_d = 1'b0;
        held_high_d    = '0;
      end
      add_cols = cur_cols + {1'b0, high_pending_q};
    end
  end

  // Saturating sum; clear it after the final unit
  assign sum_ext = {1'b0, width_sum_q} + {{(u16dw_pkg::SumW - 1){1'b0}}, add_cols};
  assign sum_sat = (sum_ext > {1'b0, u16dw_pkg::WidthCap}) ? u16dw_pkg::WidthCap
                                                            : sum_ext[u16dw_pkg::SumW-1:0];
  assign width_sum_d = s1_last_q ? '0 : sum_sat;

  assign out_valid_d = (s1_fire && s1_last_q) || (out_valid_q && !out_ready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      high_pending_q <= 1'b0;
      held_high_q    <= '0;
      width_sum_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        high_pending_q <= s1_last_q ? 1'b0 : high_pending_d;
        held_high_q    <= s1_last_q ? '0 : held_high_d;
        width_sum_q    <= width_sum_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_code_q <= code_unit_i;
      s1_last_q <= last_unit_i;
    end
    if (s1_fire && s1_last_q) begin
      out_width_q <= sum_sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign total_width_o = out_width_q;

  // Checks on the internal pipeline
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> (width_sum_q == '0) && !high_pending_q)
    else $error("string state not cleared after final unit");

  a_sum_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_sum_q <= u16dw_pkg::WidthCap)
    else $error("running sum above cap");

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && out_valid_q && !out_ready_i |=> s1_valid_q && s1_last_q)
    else $error("final unit lost while result stalled");

  a_result_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_width_q <= u16dw_pkg::WidthCap)
    else $error("result above cap");

endmodule

@@ tb/utf16_width_checker.sv @@
// Checker for the UTF-16 display width unit: predicts each string total and compares it.
`timescale 1ns / 100ps

module utf16_width_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [16:0] total_width_i,
  output int          fail_count_o,
  output int          totals_due_o
);

  // Predicted string state
  logic        high_held = 1'b0;
  logic [9:0]  held_bits = '0;
  logic [16:0] run_sum   = '0;

  // Totals predicted but not yet seen on the output channel
  logic [16:0] totals_due[$];
  logic [16:0] want;
  int          fails   = 0;
  int          due_cnt = 0;

  assign fail_count_o = fails;
  assign totals_due_o = due_cnt;

  function automatic logic spans(input logic [20:0] cp, input logic [20:0] lo,
                                 input logic [20:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  // Columns taken by one code point on the console
  function automatic logic [1:0] columns_of(input logic [20:0] cp);
    // controls, combining marks, variation selectors, joiner
    if (cp <= 21'h1F || spans(cp, 21'h7F, 21'h9F)) return 2'd0;
    if (spans(cp, 21'h0300, 21'h036F) || spans(cp, 21'h1AB0, 21'h1AFF)) return 2'd0;
    if (spans(cp, 21'h1DC0, 21'h1DFF) || spans(cp, 21'h20D0, 21'h20FF)) return 2'd0;
    if (spans(cp, 21'hFE00, 21'hFE0F) || spans(cp, 21'hFE20, 21'hFE2F)) return 2'd0;
    if (cp == 21'h200D) return 2'd0;
    // East Asian wide, fullwidth forms, emoji, CJK extension planes
    if (spans(cp, 21'h1100, 21'h115F) || cp == 21'h2329 || cp == 21'h232A) return 2'd2;
    if (spans(cp, 21'h2E80, 21'hA4CF) || spans(cp, 21'hAC00, 21'hD7A3)) return 2'd2;
    if (spans(cp, 21'hF900, 21'hFAFF) || spans(cp, 21'hFE10, 21'hFE19)) return 2'd2;
    if (spans(cp, 21'hFE30, 21'hFE6F) || spans(cp, 21'hFF00, 21'hFF60)) return 2'd2;
    if (spans(cp, 21'hFFE0, 21'hFFE6) || spans(cp, 21'h1F300, 21'h1FAFF)) return 2'd2;
    if (spans(cp, 21'h20000, 21'h3FFFD)) return 2'd2;
    return 2'd1;
  endfunction

  // Add columns to the running sum, holding it at the cap
  function automatic void add_columns(input logic [1:0] cols);
    logic [17:0] s;
    s = {1'b0, run_sum} + cols;
    run_sum = (s > {1'b0, u16dw_pkg::WidthCap}) ? u16dw_pkg::WidthCap : s[16:0];
  endfunction

  // Advance the predicted state by one accepted code unit
  function automatic void fold_unit(input logic [15:0] cu, input logic lst);
    logic hi_unit;
    logic lo_unit;
    logic paired;
    hi_unit = (cu[15:10] == 6'b110110);
    lo_unit = (cu[15:10] == 6'b110111);
    paired  = 1'b0;
    if (high_held) begin
      if (lo_unit) begin
        add_columns(columns_of(21'h10000 + {1'b0, held_bits, cu[9:0]}));
        paired = 1'b1;
      end else begin
        // held high surrogate stands alone
        add_columns(columns_of({5'b0, 6'b110110, held_bits}));
      end
      high_held = 1'b0;
      held_bits = '0;
    end
    if (!paired) begin
      if (hi_unit && !lst) begin
        high_held = 1'b1;
        held_bits = cu[9:0];
      end else begin
        add_columns(columns_of({5'b0, cu}));
      end
    end
    if (lst) begin
      totals_due = {totals_due, run_sum};
      run_sum   = '0;
      high_held = 1'b0;
      held_bits = '0;
    end
  endfunction

  // Compare results before predicting, so a stray result never meets a fresh total
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_held = 1'b0;
      held_bits = '0;
      run_sum   = '0;
      totals_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (totals_due.size() == 0) begin
          $display("%0t: unexpected total_width %0d, none expected", $time, total_width_i);
          fails++;
        end else begin
          want = totals_due.pop_front();
          if (total_width_i !== want) begin
            $display("%0t: total_width mismatch, expected %0d, actual %0d",
                     $time, want, total_width_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        fold_unit(code_unit_i, last_unit_i);
      end
    end
    due_cnt = totals_due.size();
  end

endmodule

@@ tb/tb_utf16_display_width_unit.sv @@
// Testbench top for the UTF-16 display width unit: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module tb_utf16_display_width_unit;

  localparam int RandomUnits = 1700;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit   = '0;
  logic        last_unit   = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [16:0] total_width;

  int   fail_count;
  int   totals_due;
  int   units_sent = 0;
  int   random_goal;
  logic steady = 1'b0;

  logic [15:0] string_units[$];

  always #5 clk = ~clk;

  utf16_display_width_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .code_unit_i   (code_unit),
    .last_unit_i   (last_unit),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .total_width_o (total_width)
  );

  utf16_width_checker width_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .code_unit_i   (code_unit),
    .last_unit_i   (last_unit),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .total_width_i (total_width),
    .fail_count_o  (fail_count),
    .totals_due_o  (totals_due)
  );

  // Offer one code unit, idling first unless in a steady stretch
  task automatic send_unit(input logic [15:0] cu, input logic lst);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 10));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= cu;
    last_unit <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    units_sent++;
  endtask

  // Append a code point to the string, as a surrogate pair above the BMP
  function automatic void push_point(input logic [20:0] cp);
    logic [20:0] off;
    if (cp < 21'h10000) begin
      string_units = {string_units, cp[15:0]};
    end else begin
      off = cp - 21'h10000;
      string_units = {string_units, {6'b110110, off[19:10]}};
      string_units = {string_units, {6'b110111, off[9:0]}};
    end
  endfunction

  // Ends of the width ranges and of the code space, probed at and one either side
  function automatic logic [20:0] range_bound(input int idx);
    case (idx)
      0:  return 21'h1F;     1:  return 21'h7F;     2:  return 21'h9F;
      3:  return 21'h300;    4:  return 21'h36F;    5:  return 21'h1100;
      6:  return 21'h115F;   7:  return 21'h1AB0;   8:  return 21'h1AFF;
      9:  return 21'h1DC0;   10: return 21'h1DFF;   11: return 21'h200D;
      12: return 21'h20D0;   13: return 21'h20FF;   14: return 21'h2329;
      15: return 21'h232A;   16: return 21'h2E80;   17: return 21'hA4CF;
      18: return 21'hAC00;   19: return 21'hD7A3;   20: return 21'hF900;
      21: return 21'hFAFF;   22: return 21'hFE00;   23: return 21'hFE0F;
      24: return 21'hFE10;   25: return 21'hFE19;   26: return 21'hFE20;
      27: return 21'hFE2F;   28: return 21'hFE30;   29: return 21'hFE6F;
      30: return 21'hFF00;   31: return 21'hFF60;   32: return 21'hFFE0;
      33: return 21'hFFE6;   34: return 21'hFFFF;   35: return 21'h1F300;
      36: return 21'h1FAFF;  37: return 21'h20000;  38: return 21'h3FFFD;
      default: return 21'h10FFFE;
    endcase
  endfunction

  // Build a random string of at least n units, then send it
  task automatic send_string(input int n);
    logic [20:0] cp;
    int          pick;
    string_units.delete();
    while (string_units.size() < n) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 16) begin
        cp = 21'($urandom_range(32'h20, 32'h7E));
      end else if (pick < 22) begin
        cp = 21'($urandom_range(0, 1) ? $urandom_range(0, 32'h1F)
                                      : $urandom_range(32'h7F, 32'h9F));
      end else if (pick < 32) begin
        case ($urandom_range(0, 6))
          0: cp = 21'($urandom_range(32'h0300, 32'h036F));
          1: cp = 21'($urandom_range(32'h1AB0, 32'h1AFF));
          2: cp = 21'($urandom_range(32'h1DC0, 32'h1DFF));
          3: cp = 21'($urandom_range(32'h20D0, 32'h20FF));
          4: cp = 21'($urandom_range(32'hFE00, 32'hFE0F));
          5: cp = 21'($urandom_range(32'hFE20, 32'hFE2F));
          default: cp = 21'h200D;
        endcase
      end else if (pick < 46) begin
        case ($urandom_range(0, 8))
          0: cp = 21'($urandom_range(32'h1100, 32'h115F));
          1: cp = 21'($urandom_range(32'h2329, 32'h232A));
          2: cp = 21'($urandom_range(32'h2E80, 32'hA4CF));
          3: cp = 21'($urandom_range(32'hAC00, 32'hD7A3));
          4: cp = 21'($urandom_range(32'hF900, 32'hFAFF));
          5: cp = 21'($urandom_range(32'hFE10, 32'hFE19));
          6: cp = 21'($urandom_range(32'hFE30, 32'hFE6F));
          7: cp = 21'($urandom_range(32'hFF00, 32'hFF60));
          default: cp = 21'($urandom_range(32'hFFE0, 32'hFFE6));
        endcase
      end else if (pick < 64) begin
        // well-formed surrogate pairs
        case ($urandom_range(0, 2))
          0: cp = 21'($urandom_range(32'h1F300, 32'h1FAFF));
          1: cp = 21'($urandom_range(32'h20000, 32'h3FFFD));
          default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
      end else if (pick < 72) begin
        cp = 21'($urandom_range(32'hD800, 32'hDBFF));
      end else if (pick < 78) begin
        cp = 21'($urandom_range(32'hDC00, 32'hDFFF));
      end else if (pick < 88) begin
        cp = 21'(range_bound(int'($urandom_range(0, 39))) + $urandom_range(0, 2) - 1);
      end else begin
        cp = 21'($urandom_range(0, 32'hFFFF));
      end
      push_point(cp);
    end
    for (int k = 0; k < string_units.size(); k++) begin
      send_unit(string_units[k], k == string_units.size() - 1);
    end
  endtask

  // Receiver: hold out_ready low for a random stall before each result, unless steady
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : int'($urandom_range(0, 10));
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single units at the extremes of the field
    send_unit(16'h0000, 1'b1);
    send_unit(16'hFFFF, 1'b1);
    // Combining marks, joiner and the ends of the main CJK block
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0300, 1'b0);
    send_unit(16'h036F, 1'b0);
    send_unit(16'h200D, 1'b0);
    send_unit(16'h2E80, 1'b0);
    send_unit(16'hA4CF, 1'b1);
    // Pairs to the start of the emoji block and both ends of the extension planes
    send_unit(16'hD83C, 1'b0);
    send_unit(16'hDF00, 1'b1);
    send_unit(16'hD840, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hD8BF, 1'b0);
    send_unit(16'hDFFD, 1'b1);
    // Held high followed by a plain unit
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b1);
    // High surrogate as the last unit, then a lone low surrogate
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'hDFFF, 1'b1);
    // Two highs in a row, the second one paired
    send_unit(16'hD800, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC00, 1'b1);
    // Wide character then a trailing high surrogate
    send_unit(16'h4E00, 1'b0);
    send_unit(16'hD83C, 1'b1);

    // Random strings, mostly short, with occasional steady stretches
    random_goal = units_sent + RandomUnits;
    while (units_sent < random_goal) begin
      if ($urandom_range(0, 11) == 0) steady = ~steady;
      send_string(($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 60))
                                              : int'($urandom_range(1, 8)));
    end

    // Close with a short string at the usual pace
    steady = 1'b0;
    send_string(3);
    in_valid <= 1'b0;

    // Drain outstanding totals, then allow for the pipeline
    do @(negedge clk); while (totals_due != 0);
    repeat (6) @(posedge clk);
    if (fail_count == 0 && totals_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
